FILE: sv/rva_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rva_pkg;

  // Field and datapath widths
  localparam int PIX_W      = 12;
  localparam int DIM_W      = 13;
  localparam int Q16_W      = 16;
  localparam int STR_W      = 9;
  localparam int ALPHA_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Squares of 13-bit magnitudes, and sums of two of them
  localparam int SQ_W       = 2 * DIM_W;
  localparam int DSQ_W      = SQ_W + 1;
  // D * 2^32 / M: numerator and quotient width
  localparam int FRAC_SHIFT = 32;
  localparam int QUO_W      = DSQ_W + FRAC_SHIFT;
  // Square root of the padded quotient
  localparam int RATIO_W    = (QUO_W + 1) / 2;
  localparam int RAD_W      = 2 * RATIO_W;
  // Ramp value t in 0..1.0, unsigned Q.16
  localparam int T_W        = Q16_W + 1;
  localparam int PROD_W     = T_W + STR_W;
  localparam int SCALE_W    = PROD_W + 8;
  localparam int ALPHA_LSB  = 24;

  localparam logic [T_W-1:0] ONE_Q16 = T_W'(65536);

  // Register reset values
  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = DIM_W'(480);
  localparam logic [Q16_W-1:0] RST_INNER_RADIUS = Q16_W'(32768);
  localparam logic [STR_W-1:0] RST_STRENGTH     = STR_W'(179);

  // Register indexes on the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_INNER_RADIUS = 2'd2,
    CFG_STRENGTH     = 2'd3
  } cfg_idx_t;

  // How the ramp value is formed for one pixel
  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_FULL = 2'd1,
    SEL_FRAC = 2'd2
  } ramp_sel_t;

  // Squared distance and squared diagonal of one pixel
  typedef struct packed {
    logic             valid;
    logic [DSQ_W-1:0] d;
    logic [DSQ_W-1:0] m;
  } dist_item_t;

  // Normalized radius of one pixel
  typedef struct packed {
    logic               valid;
    logic [RATIO_W-1:0] ratio;
    logic               m_zero;
  } ratio_item_t;

  // Finished opacity of one pixel
  typedef struct packed {
    logic               valid;
    logic [ALPHA_W-1:0] alpha;
  } alpha_item_t;

endpackage

`default_nettype wire

FILE: sv/rva_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rva_in_if;
  logic                      valid;
  logic                      ready;
  logic [rva_pkg::PIX_W-1:0] pixel_x;
  logic [rva_pkg::PIX_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

FILE: sv/rva_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rva_out_if;
  logic                        valid;
  logic                        ready;
  logic [rva_pkg::ALPHA_W-1:0] alpha;

  modport source (output valid, output alpha, input ready);
  modport sink (input valid, input alpha, output ready);
endinterface

`default_nettype wire

FILE: sv/rva_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rva_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rva_pkg::CFG_IDX_W-1:0]  index;
  logic [rva_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/rva_dist.sv
`timescale 1ns / 1ps
`default_nettype none

// Three stages: center offsets, squares, sums.
module rva_dist (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [rva_pkg::PIX_W-1:0] pixel_x,
  input  wire logic [rva_pkg::PIX_W-1:0] pixel_y,
  input  wire logic [rva_pkg::DIM_W-1:0] frame_width,
  input  wire logic [rva_pkg::DIM_W-1:0] frame_height,
  output rva_pkg::dist_item_t            dist_o
);

  logic                      a_v_r;
  logic [rva_pkg::DIM_W-1:0] dx_r, dy_r, w_r, h_r;
  logic [rva_pkg::DIM_W-1:0] dx_nxt, dy_nxt, tx, ty;

  logic                      b_v_r;
  logic [rva_pkg::SQ_W-1:0]  dx2_r, dy2_r, w2_r, h2_r;

  logic                      c_v_r;
  logic [rva_pkg::DSQ_W-1:0] d_r, m_r;

  // Offsets of twice the position from the frame size
  always_comb begin
    tx = {pixel_x, 1'b0};
    ty = {pixel_y, 1'b0};
    dx_nxt = (tx >= frame_width) ? (tx - frame_width) : (frame_width - tx);
    dy_nxt = (ty >= frame_height) ? (ty - frame_height) : (frame_height - ty);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      w_r   <= frame_width;
      h_r   <= frame_height;
      dx2_r <= rva_pkg::SQ_W'(dx_r) * rva_pkg::SQ_W'(dx_r);
      dy2_r <= rva_pkg::SQ_W'(dy_r) * rva_pkg::SQ_W'(dy_r);
      w2_r  <= rva_pkg::SQ_W'(w_r) * rva_pkg::SQ_W'(w_r);
      h2_r  <= rva_pkg::SQ_W'(h_r) * rva_pkg::SQ_W'(h_r);
      d_r   <= rva_pkg::DSQ_W'(dx2_r) + rva_pkg::DSQ_W'(dy2_r);
      m_r   <= rva_pkg::DSQ_W'(w2_r) + rva_pkg::DSQ_W'(h2_r);
    end
  end

  assign dist_o.valid = c_v_r;
  assign dist_o.d     = d_r;
  assign dist_o.m     = m_r;

endmodule

`default_nettype wire

FILE: sv/rva_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage. The starting remainder
// must be below the divisor; numerator bits are shifted in MSB first.
module rva_div #(
  parameter int STEPS  = 16,
  parameter int DEN_W  = 17,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [DEN_W-1:0]  in_rem,
  input  wire logic [STEPS-1:0]  in_num,
  input  wire logic [DEN_W-1:0]  in_den,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [STEPS-1:0]       out_quo,
  output logic [SIDE_W-1:0]      out_side
);

  logic              v_r    [STEPS];
  logic [DEN_W-1:0]  rem_r  [STEPS];
  logic [STEPS-1:0]  num_r  [STEPS];
  logic [STEPS-1:0]  quo_r  [STEPS];
  logic [DEN_W-1:0]  den_r  [STEPS];
  logic [SIDE_W-1:0] side_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    logic              v_in;
    logic [DEN_W-1:0]  rem_in;
    logic [STEPS-1:0]  num_in;
    logic [STEPS-1:0]  quo_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;
    logic [DEN_W-1:0]  rem_nxt;
    logic [STEPS-1:0]  quo_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_rem;
      assign num_in  = in_num;
      assign quo_in  = '0;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign num_in  = num_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
    end

    // Shift in the next numerator bit, subtract the divisor when it fits
    always_comb begin
      trial   = {rem_in, num_in[STEPS-1-k]};
      diff    = trial - {1'b0, den_in};
      ge      = (trial >= {1'b0, den_in});
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_nxt = quo_in;
      quo_nxt[STEPS-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        num_r[k]  <= num_in;
        quo_r[k]  <= quo_nxt;
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_quo   = quo_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];

endmodule

`default_nettype wire

FILE: sv/rva_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Digit-by-digit integer square root, one root bit per stage.
module rva_isqrt #(
  parameter int RES_W  = 30,
  parameter int SIDE_W = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [2*RES_W-1:0]   in_rad,
  input  wire logic [SIDE_W-1:0]    in_side,
  output logic                      out_valid,
  output logic [RES_W-1:0]          out_root,
  output logic [SIDE_W-1:0]         out_side
);

  localparam int RAD_W = 2 * RES_W;
  localparam int REM_W = RES_W + 1;

  logic              v_r    [RES_W];
  logic [RAD_W-1:0]  rad_r  [RES_W];
  logic [REM_W-1:0]  rem_r  [RES_W];
  logic [RES_W-1:0]  root_r [RES_W];
  logic [SIDE_W-1:0] side_r [RES_W];

  for (genvar k = 0; k < RES_W; k++) begin : g_stage
    logic              v_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [RES_W-1:0]  root_in;
    logic [SIDE_W-1:0] side_in;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  tval;
    logic [REM_W+1:0]  diff;
    logic              ge;
    logic [REM_W-1:0]  rem_nxt;
    logic [RES_W-1:0]  root_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rad_in  = in_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    // Bring down two radicand bits, try root*4+1
    always_comb begin
      trial    = {rem_in, rad_in[RAD_W-1-2*k -: 2]};
      tval     = {1'b0, root_in, 2'b01};
      diff     = trial - tval;
      ge       = (trial >= tval);
      rem_nxt  = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      root_nxt = {root_in[RES_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_in;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = v_r[RES_W-1];
  assign out_root  = root_r[RES_W-1];
  assign out_side  = side_r[RES_W-1];

endmodule

`default_nettype wire

FILE: sv/rva_ramp.sv
`timescale 1ns / 1ps
`default_nettype none

// Ramp from inner radius to corner, then scale by strength.
module rva_ramp (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic [rva_pkg::Q16_W-1:0] inner_radius,
  input  wire logic [rva_pkg::STR_W-1:0] strength,
  input  wire rva_pkg::ratio_item_t      ratio_i,
  output rva_pkg::alpha_item_t           alpha_o
);

  localparam int SEL_W = $bits(rva_pkg::ramp_sel_t);

  logic [rva_pkg::RATIO_W-1:0] r_ext;
  logic [rva_pkg::RATIO_W-1:0] diff;
  logic [rva_pkg::T_W-1:0]     den_nxt;
  rva_pkg::ramp_sel_t          sel_nxt;

  logic                        pre_v_r;
  rva_pkg::ramp_sel_t          sel_r;
  logic [rva_pkg::T_W-1:0]     rem_r;
  logic [rva_pkg::T_W-1:0]     den_r;

  logic                        div_valid;
  logic [rva_pkg::Q16_W-1:0]   div_quo;
  logic [SEL_W-1:0]            div_side;
  rva_pkg::ramp_sel_t          div_sel;
  logic [rva_pkg::T_W-1:0]     t_val;

  logic                        p_v_r;
  logic [rva_pkg::PROD_W-1:0]  p_r;
  logic [rva_pkg::SCALE_W-1:0] scaled;
  logic [rva_pkg::SCALE_W-rva_pkg::ALPHA_LSB-1:0] hi;

  // Classify: inside radius, past the corner, or a fraction to divide out
  always_comb begin
    r_ext   = rva_pkg::RATIO_W'(inner_radius);
    diff    = ratio_i.ratio - r_ext;
    den_nxt = rva_pkg::ONE_Q16 - rva_pkg::T_W'(inner_radius);
    if (ratio_i.m_zero || (ratio_i.ratio <= r_ext)) begin
      sel_nxt = rva_pkg::SEL_ZERO;
    end else if (diff >= rva_pkg::RATIO_W'(den_nxt)) begin
      sel_nxt = rva_pkg::SEL_FULL;
    end else begin
      sel_nxt = rva_pkg::SEL_FRAC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_v_r <= 1'b0;
    end else if (en) begin
      pre_v_r <= ratio_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_r <= sel_nxt;
      rem_r <= {1'b0, diff[rva_pkg::Q16_W-1:0]};
      den_r <= den_nxt;
    end
  end

  // (diff << 16) / den, with diff below den
  rva_div #(
    .STEPS  (rva_pkg::Q16_W),
    .DEN_W  (rva_pkg::T_W),
    .SIDE_W (SEL_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pre_v_r),
    .in_rem    (rem_r),
    .in_num    ('0),
    .in_den    (den_r),
    .in_side   (SEL_W'(sel_r)),
    .out_valid (div_valid),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // Pick the ramp value
  always_comb begin
    div_sel = rva_pkg::ramp_sel_t'(div_side);
    case (div_sel)
      rva_pkg::SEL_ZERO: t_val = '0;
      rva_pkg::SEL_FULL: t_val = rva_pkg::ONE_Q16;
      rva_pkg::SEL_FRAC: t_val = {1'b0, div_quo};
      default:           t_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= rva_pkg::PROD_W'(t_val) * rva_pkg::PROD_W'(strength);
    end
  end

  // Times 255, drop 24 fraction bits, saturate
  always_comb begin
    scaled = {p_r, 8'b0} - rva_pkg::SCALE_W'(p_r);
    hi     = scaled[rva_pkg::SCALE_W-1:rva_pkg::ALPHA_LSB];
    alpha_o.valid = p_v_r;
    alpha_o.alpha = (|hi[$bits(hi)-1:rva_pkg::ALPHA_W]) ? '1 : hi[rva_pkg::ALPHA_W-1:0];
  end

endmodule

`default_nettype wire

FILE: sv/radial_vignette_alpha_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Role    Fields             Transfer
// in_chan   sink    pixel_x, pixel_y   valid & ready
// out_chan  source  alpha              valid & ready
// cfg_chan  sink    index, data        valid & ready (ready always high)
//
// One pixel per clock while the skid register is empty. The path runs through the
// 59-stage distance divider, the 30-stage square root and the 16-stage ramp divider,
// one result bit per stage each.
// Synchronous reset clears all valid bits and loads the register defaults.
// A stalled result goes to a one-entry skid register; while it is full the
// whole pipeline holds and in_chan.ready is low.
module radial_vignette_alpha_core (
  input  wire logic clk,
  input  wire logic rst_n,
  rva_in_if.sink    in_chan,
  rva_out_if.source out_chan,
  rva_cfg_if.sink   cfg_chan
);

  logic [rva_pkg::DIM_W-1:0]   fw_r;
  logic [rva_pkg::DIM_W-1:0]   fh_r;
  logic [rva_pkg::Q16_W-1:0]   ir_r;
  logic [rva_pkg::STR_W-1:0]   st_r;

  logic                        en;
  rva_pkg::dist_item_t         dist_item;
  logic                        q_valid;
  logic [rva_pkg::QUO_W-1:0]   q_val;
  logic                        q_mzero;
  logic                        sq_valid;
  logic [rva_pkg::RATIO_W-1:0] sq_root;
  logic                        sq_mzero;
  rva_pkg::ratio_item_t        ratio_item;
  rva_pkg::alpha_item_t        alpha_item;

  logic                        out_valid_r, out_valid_nxt;
  logic [rva_pkg::ALPHA_W-1:0] out_alpha_r, out_alpha_nxt;
  logic                        skid_valid_r, skid_valid_nxt;
  logic [rva_pkg::ALPHA_W-1:0] skid_alpha_r, skid_alpha_nxt;

  // Configuration registers
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= rva_pkg::RST_FRAME_WIDTH;
      fh_r <= rva_pkg::RST_FRAME_HEIGHT;
      ir_r <= rva_pkg::RST_INNER_RADIUS;
      st_r <= rva_pkg::RST_STRENGTH;
    end else if (cfg_chan.valid) begin
      case (rva_pkg::cfg_idx_t'(cfg_chan.index))
        rva_pkg::CFG_FRAME_WIDTH:  fw_r <= cfg_chan.data[rva_pkg::DIM_W-1:0];
        rva_pkg::CFG_FRAME_HEIGHT: fh_r <= cfg_chan.data[rva_pkg::DIM_W-1:0];
        rva_pkg::CFG_INNER_RADIUS: ir_r <= cfg_chan.data[rva_pkg::Q16_W-1:0];
        rva_pkg::CFG_STRENGTH:     st_r <= cfg_chan.data[rva_pkg::STR_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline moves whenever the skid entry is free
  assign en            = !skid_valid_r;
  assign in_chan.ready = en;

  rva_dist u_dist (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_chan.valid),
    .pixel_x      (in_chan.pixel_x),
    .pixel_y      (in_chan.pixel_y),
    .frame_width  (fw_r),
    .frame_height (fh_r),
    .dist_o       (dist_item)
  );

  // D * 2^32 / M
  rva_div #(
    .STEPS  (rva_pkg::QUO_W),
    .DEN_W  (rva_pkg::DSQ_W),
    .SIDE_W (1)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dist_item.valid),
    .in_rem    ('0),
    .in_num    ({dist_item.d, {rva_pkg::FRAC_SHIFT{1'b0}}}),
    .in_den    (dist_item.m),
    .in_side   (dist_item.m == '0),
    .out_valid (q_valid),
    .out_quo   (q_val),
    .out_side  (q_mzero)
  );

  rva_isqrt #(
    .RES_W  (rva_pkg::RATIO_W),
    .SIDE_W (1)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (q_valid),
    .in_rad    (rva_pkg::RAD_W'(q_val)),
    .in_side   (q_mzero),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_mzero)
  );

  assign ratio_item.valid  = sq_valid;
  assign ratio_item.ratio  = sq_root;
  assign ratio_item.m_zero = sq_mzero;

  rva_ramp u_ramp (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .inner_radius (ir_r),
    .strength     (st_r),
    .ratio_i      (ratio_item),
    .alpha_o      (alpha_item)
  );

  // Output register with skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_alpha_nxt  = out_alpha_r;
    skid_valid_nxt = skid_valid_r;
    skid_alpha_nxt = skid_alpha_r;
    if (skid_valid_r) begin
      if (out_chan.ready) begin
        out_valid_nxt  = 1'b1;
        out_alpha_nxt  = skid_alpha_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || out_chan.ready) begin
      out_valid_nxt = alpha_item.valid;
      out_alpha_nxt = alpha_item.alpha;
    end else if (alpha_item.valid) begin
      skid_valid_nxt = 1'b1;
      skid_alpha_nxt = alpha_item.alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_alpha_r  <= out_alpha_nxt;
    skid_alpha_r <= skid_alpha_nxt;
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.alpha = out_alpha_r;

  // The skid entry only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full while output register empty");

  // A waiting skid entry keeps its value
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_chan.ready) |=> (skid_valid_r && $stable(skid_alpha_r)))
    else $error("skid entry changed while output stalled");

  // Draining the skid entry moves it into the output register
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_chan.ready) |=>
      (out_valid_r && !skid_valid_r && (out_alpha_r == $past(skid_alpha_r))))
    else $error("skid entry lost on drain");

endmodule

`default_nettype wire
